FILE: rtl/ptt_pkg.sv
// ptt_pkg: shared widths, codes and types of the periodic timer table.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ptt_pkg;

   localparam int TIMER_SLOTS = 16;
   localparam int TIME_BITS   = 48;
   localparam int MAX_FIRE    = 16;
   localparam int ID_BITS     = 31;
   localparam int PERIOD_BITS = 31;
   localparam int CODE_BITS   = 2;

   localparam int IDX_BITS      = $clog2(TIMER_SLOTS);
   localparam int SCAN_BITS     = $clog2(TIMER_SLOTS + 1);
   localparam int FIRE_CNT_BITS = $clog2(MAX_FIRE + 1);

   // request tdata: period_ms, timer_ref, zero fill to whole bytes
   localparam int REQ_PERIOD_LSB = 0;
   localparam int REQ_REF_LSB    = PERIOD_BITS;
   localparam int REQ_DATA_BITS  = ((PERIOD_BITS + ID_BITS + 7) / 8) * 8;

   // response tdata: timer_num, status, zero fill to whole bytes
   localparam int RSP_DATA_BITS = ((ID_BITS + CODE_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - ID_BITS - CODE_BITS;

   localparam logic [CODE_BITS-1:0] OP_ADD    = 2'd0;
   localparam logic [CODE_BITS-1:0] OP_REMOVE = 2'd1;
   localparam logic [CODE_BITS-1:0] OP_TICK   = 2'd2;

   localparam logic [CODE_BITS-1:0] KIND_ADD    = 2'd0;
   localparam logic [CODE_BITS-1:0] KIND_REMOVE = 2'd1;
   localparam logic [CODE_BITS-1:0] KIND_FIRE   = 2'd2;

   localparam logic [CODE_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [CODE_BITS-1:0] STATUS_FULL      = 2'd1;
   localparam logic [CODE_BITS-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [TIME_BITS-1:0]   deadline;
      logic [PERIOD_BITS-1:0] period;
      logic [ID_BITS-1:0]     id;
   } slot_entry_type;

   typedef struct packed {
      logic                 valid;
      logic [CODE_BITS-1:0] kind;
      logic [ID_BITS-1:0]   num;
      logic [CODE_BITS-1:0] status;
      logic                 last;
   } rsp_item_type;

endpackage

FILE: rtl/ptt_rsp_reg.sv
// ptt_rsp_reg: one-entry output register for the response stream.
// Depends on ptt_pkg for the response item type and field widths.
`timescale 1ns / 1ps

module ptt_rsp_reg (
   input  logic                               clock,
   input  logic                               reset,
   input  ptt_pkg::rsp_item_type              push,
   output logic                               free,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ptt_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,  // timer_num, status
   output logic [ptt_pkg::CODE_BITS-1:0]      rsp_tuser,  // kind
   output logic                               rsp_tlast
);

   logic                             valid_ff;
   logic [ptt_pkg::CODE_BITS-1:0]    kind_ff;
   logic [ptt_pkg::ID_BITS-1:0]      num_ff;
   logic [ptt_pkg::CODE_BITS-1:0]    status_ff;
   logic                             last_ff;

   assign free       = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{ptt_pkg::RSP_PAD_BITS{1'b0}}, status_ff, num_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (push.valid) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         kind_ff   <= push.kind;
         num_ff    <= push.num;
         status_ff <= push.status;
         last_ff   <= push.last;
      end
   end

endmodule

FILE: rtl/ptt_engine.sv
// ptt_engine: sequencer and slot memory of the timer table (add, remove, tick scans).
// Depends on ptt_pkg; feeds result items to ptt_rsp_reg.
`timescale 1ns / 1ps

module ptt_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ptt_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic [ptt_pkg::CODE_BITS-1:0]      req_tuser,
   input  logic                               rsp_free,
   output ptt_pkg::rsp_item_type              push
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ADD   = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DONE  = 3'd3;
   localparam logic [2:0] ST_FLUSH = 3'd4;

   localparam logic [ptt_pkg::SCAN_BITS-1:0] SCAN_END =
      ptt_pkg::SCAN_BITS'(ptt_pkg::TIMER_SLOTS);
   localparam logic [ptt_pkg::IDX_BITS-1:0] LAST_IDX =
      ptt_pkg::IDX_BITS'(ptt_pkg::TIMER_SLOTS - 1);
   localparam logic [ptt_pkg::FIRE_CNT_BITS-1:0] FIRE_LAST =
      ptt_pkg::FIRE_CNT_BITS'(ptt_pkg::MAX_FIRE - 1);

   ptt_pkg::slot_entry_type slot_mem [ptt_pkg::TIMER_SLOTS];
   ptt_pkg::slot_entry_type rd_data_ff;
   ptt_pkg::slot_entry_type wr_data;
   logic [ptt_pkg::IDX_BITS-1:0] rd_addr;
   logic [ptt_pkg::IDX_BITS-1:0] wr_addr;
   logic                         mem_we;

   logic [2:0] state_ff, state_in;
   logic [ptt_pkg::CODE_BITS-1:0]   op_ff, op_in;
   logic [ptt_pkg::PERIOD_BITS-1:0] period_ff, period_in;
   logic [ptt_pkg::ID_BITS-1:0]     ref_ff, ref_in;
   logic [ptt_pkg::TIME_BITS-1:0]   now_ff, now_in;
   logic [ptt_pkg::ID_BITS-1:0]     id_ctr_ff, id_ctr_in;
   logic [ptt_pkg::TIMER_SLOTS-1:0] valid_ff, valid_in;
   logic [ptt_pkg::TIMER_SLOTS-1:0] fired_ff, fired_in;
   logic [ptt_pkg::SCAN_BITS-1:0]   scan_ff, scan_in;
   logic                            eval_ff, eval_in;
   logic [ptt_pkg::IDX_BITS-1:0]    eval_idx_ff, eval_idx_in;
   logic                            found_ff, found_in;
   logic [ptt_pkg::IDX_BITS-1:0]    found_idx_ff, found_idx_in;
   logic                            best_found_ff, best_found_in;
   logic [ptt_pkg::IDX_BITS-1:0]    best_idx_ff, best_idx_in;
   logic [ptt_pkg::TIME_BITS-1:0]   best_age_ff, best_age_in;
   logic [ptt_pkg::ID_BITS-1:0]     best_id_ff, best_id_in;
   logic [ptt_pkg::PERIOD_BITS-1:0] best_period_ff, best_period_in;
   logic                            held_ff, held_in;
   logic [ptt_pkg::ID_BITS-1:0]     held_id_ff, held_id_in;
   logic [ptt_pkg::FIRE_CNT_BITS-1:0] fire_cnt_ff, fire_cnt_in;

   logic                           free_any;
   logic [ptt_pkg::IDX_BITS-1:0]   free_idx;
   logic [ptt_pkg::TIME_BITS-1:0]  age;
   logic                           cand;
   logic                           better;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int s = ptt_pkg::TIMER_SLOTS - 1; s >= 0; s--) begin
         if (!valid_ff[s]) begin
            free_idx = ptt_pkg::IDX_BITS'(s);
         end
      end
   end
   assign free_any = ~&valid_ff;

   // expired when now - deadline lies in the lower half of the time circle
   assign age    = now_ff - rd_data_ff.deadline;
   assign cand   = valid_ff[eval_idx_ff] && !fired_ff[eval_idx_ff] &&
                   !age[ptt_pkg::TIME_BITS-1];
   assign better = (age > best_age_ff) ||
                   ((age == best_age_ff) && (rd_data_ff.id < best_id_ff));

   assign rd_addr = (scan_ff < SCAN_END) ? scan_ff[ptt_pkg::IDX_BITS-1:0] : '0;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      period_in      = period_ff;
      ref_in         = ref_ff;
      now_in         = now_ff;
      id_ctr_in      = id_ctr_ff;
      valid_in       = valid_ff;
      fired_in       = fired_ff;
      scan_in        = scan_ff;
      eval_in        = 1'b0;
      eval_idx_in    = rd_addr;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_age_in    = best_age_ff;
      best_id_in     = best_id_ff;
      best_period_in = best_period_ff;
      held_in        = held_ff;
      held_id_in     = held_id_ff;
      fire_cnt_in    = fire_cnt_ff;
      mem_we         = 1'b0;
      wr_addr        = best_idx_ff;
      wr_data.deadline = now_ff + ptt_pkg::TIME_BITS'(best_period_ff);
      wr_data.period   = best_period_ff;
      wr_data.id       = best_id_ff;
      push           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               period_in = req_tdata[ptt_pkg::REQ_PERIOD_LSB +: ptt_pkg::PERIOD_BITS];
               ref_in    = req_tdata[ptt_pkg::REQ_REF_LSB +: ptt_pkg::ID_BITS];
               case (req_tuser)
                  ptt_pkg::OP_ADD: begin
                     state_in = ST_ADD;
                  end
                  ptt_pkg::OP_REMOVE: begin
                     found_in = 1'b0;
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
                  ptt_pkg::OP_TICK: begin
                     now_in        = now_ff + 1'b1;
                     fired_in      = '0;
                     fire_cnt_in   = '0;
                     held_in       = 1'b0;
                     best_found_in = 1'b0;
                     scan_in       = '0;
                     state_in      = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD: begin
            if (rsp_free) begin
               push.valid = 1'b1;
               push.kind  = ptt_pkg::KIND_ADD;
               push.last  = 1'b1;
               if (free_any) begin
                  mem_we           = 1'b1;
                  wr_addr          = free_idx;
                  wr_data.deadline = now_ff + ptt_pkg::TIME_BITS'(period_ff);
                  wr_data.period   = period_ff;
                  wr_data.id       = id_ctr_ff + 1'b1;
                  valid_in[free_idx] = 1'b1;
                  id_ctr_in        = id_ctr_ff + 1'b1;
                  push.num         = id_ctr_ff + 1'b1;
                  push.status      = ptt_pkg::STATUS_OK;
               end else begin
                  push.num    = '0;
                  push.status = ptt_pkg::STATUS_FULL;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_ff < SCAN_END) begin
               eval_in = 1'b1;
               scan_in = scan_ff + 1'b1;
            end
            if (eval_ff) begin
               if (op_ff == ptt_pkg::OP_REMOVE) begin
                  if (valid_ff[eval_idx_ff] && (rd_data_ff.id == ref_ff) && !found_ff) begin
                     found_in     = 1'b1;
                     found_idx_in = eval_idx_ff;
                  end
               end else if (cand && (!best_found_ff || better)) begin
                  best_found_in  = 1'b1;
                  best_idx_in    = eval_idx_ff;
                  best_age_in    = age;
                  best_id_in     = rd_data_ff.id;
                  best_period_in = rd_data_ff.period;
               end
               if (eval_idx_ff == LAST_IDX) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (op_ff == ptt_pkg::OP_REMOVE) begin
               if (rsp_free) begin
                  push.valid  = 1'b1;
                  push.kind   = ptt_pkg::KIND_REMOVE;
                  push.num    = ref_ff;
                  push.status = found_ff ? ptt_pkg::STATUS_OK : ptt_pkg::STATUS_NOT_FOUND;
                  push.last   = 1'b1;
                  if (found_ff) begin
                     valid_in[found_idx_ff] = 1'b0;
                  end
                  state_in = ST_IDLE;
               end
            end else if (!best_found_ff) begin
               state_in = ST_FLUSH;
            end else if (!held_ff || rsp_free) begin
               // previous fire is not last; reload the winner, it is skipped from now on
               if (held_ff) begin
                  push.valid  = 1'b1;
                  push.kind   = ptt_pkg::KIND_FIRE;
                  push.num    = held_id_ff;
                  push.status = ptt_pkg::STATUS_OK;
                  push.last   = 1'b0;
               end
               mem_we                = 1'b1;
               fired_in[best_idx_ff] = 1'b1;
               held_in               = 1'b1;
               held_id_in            = best_id_ff;
               fire_cnt_in           = fire_cnt_ff + 1'b1;
               best_found_in         = 1'b0;
               scan_in               = '0;
               state_in = (fire_cnt_ff == FIRE_LAST) ? ST_FLUSH : ST_SCAN;
            end
         end
         ST_FLUSH: begin
            if (!held_ff) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               push.valid  = 1'b1;
               push.kind   = ptt_pkg::KIND_FIRE;
               push.num    = held_id_ff;
               push.status = ptt_pkg::STATUS_OK;
               push.last   = 1'b1;
               held_in     = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // slot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         id_ctr_ff     <= '0;
         valid_ff      <= '0;
         fired_ff      <= '0;
         scan_ff       <= '0;
         eval_ff       <= 1'b0;
         found_ff      <= 1'b0;
         best_found_ff <= 1'b0;
         held_ff       <= 1'b0;
         fire_cnt_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         id_ctr_ff     <= id_ctr_in;
         valid_ff      <= valid_in;
         fired_ff      <= fired_in;
         scan_ff       <= scan_in;
         eval_ff       <= eval_in;
         found_ff      <= found_in;
         best_found_ff <= best_found_in;
         held_ff       <= held_in;
         fire_cnt_ff   <= fire_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      period_ff      <= period_in;
      ref_ff         <= ref_in;
      eval_idx_ff    <= eval_idx_in;
      found_idx_ff   <= found_idx_in;
      best_idx_ff    <= best_idx_in;
      best_age_ff    <= best_age_in;
      best_id_ff     <= best_id_in;
      best_period_ff <= best_period_in;
      held_id_ff     <= held_id_in;
   end

endmodule

FILE: rtl/periodic_timer_table.sv
// periodic_timer_table: top level of the periodic timer table.
// Depends on ptt_pkg, ptt_engine and ptt_rsp_reg.
`timescale 1ns / 1ps

// One request transaction is taken at a time; ready is high only while the
// sequencer is idle. Timer state lives in a slot memory with one read and one
// write port. A remove sweeps that read port once over all TIMER_SLOTS entries,
// and a tick sweeps it once per fired timer and once more to find no further
// expired timer, that last sweep left out when MAX_FIRE timers fire; an add
// does not sweep. Waiting on rsp_tready stalls the sequencer. Every fired timer
// is reloaded as soon as it is picked. Results pass through a one-entry output
// register, so the next request is accepted while the last response is still
// pending. No clearing pass is needed after reset.

module periodic_timer_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ptt_pkg::REQ_DATA_BITS-1:0]  req_tdata,  // period_ms, timer_ref
   input  logic [ptt_pkg::CODE_BITS-1:0]      req_tuser,  // operation
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ptt_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,  // timer_num, status
   output logic [ptt_pkg::CODE_BITS-1:0]      rsp_tuser,  // kind
   output logic                               rsp_tlast
);

   ptt_pkg::rsp_item_type push;
   logic                  rsp_free;

   ptt_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_free   (rsp_free),
      .push       (push)
   );

   ptt_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .free       (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // add answers always close their request
   a_add_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ptt_pkg::KIND_ADD)) |-> rsp_tlast)
      else $error("add answer without tlast");

   // fired timers always report ok
   a_fire_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ptt_pkg::KIND_FIRE)) |->
      (rsp_tdata[ptt_pkg::ID_BITS +: ptt_pkg::CODE_BITS] == ptt_pkg::STATUS_OK))
      else $error("fire transaction with nonzero status");

   // a full table answers with id zero
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid &&
       (rsp_tdata[ptt_pkg::ID_BITS +: ptt_pkg::CODE_BITS] == ptt_pkg::STATUS_FULL)) |->
      ((rsp_tuser == ptt_pkg::KIND_ADD) && (rsp_tdata[ptt_pkg::ID_BITS-1:0] == '0)))
      else $error("table full status on a wrong transaction");

   // no response is pushed while the output register still holds one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> rsp_free)
      else $error("response register overwritten");

endmodule
